>>> rtl/core/lfsm_pkg.sv
// Shared types, constants and the transition table of the lamp fade controller.
// Used by lfsm_ramp and lamp_fade_state_machine in rtl/core; depends on nothing.
package lfsm_pkg;

    localparam int CHANNELS_DEF  = 4;
    localparam int FULL_DUTY_DEF = 31999;

    localparam int FRAC_BITS = 10;
    localparam int TICK_W    = 16;
    localparam int VAL_W     = 16;
    localparam int DUTY_W    = 15;
    localparam int CH_W      = 2;
    localparam int EV_W      = 2;
    localparam int ST_W      = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICK_W-1:0] FADE_RESET = 16'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT = 2'd1;

    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_SHORT = 2'd1;
    localparam logic [EV_W-1:0] EV_LONG  = 2'd2;

    typedef enum logic [ST_W-1:0] {
        ST_OFF  = 2'd0,
        ST_FIN  = 2'd1,
        ST_ON   = 2'd2,
        ST_FOUT = 2'd3
    } lamp_st_t;

    typedef struct packed {
        logic     go;
        lamp_st_t st;
    } trans_t;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] ticks;
        logic [TICK_W-1:0] count;
    } ramp_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
    } ramp_rsp_t;

    function automatic trans_t next_state(lamp_st_t cur, logic [EV_W-1:0] ev);
        trans_t t;
        t.go = 1'b0;
        t.st = cur;
        if (ev == EV_LONG) begin
            t.go = 1'b1;
            t.st = (cur == ST_OFF) ? ST_ON : ST_OFF;
        end else if (ev == EV_SHORT) begin
            if (cur == ST_OFF) begin
                t.go = 1'b1;
                t.st = ST_FIN;
            end else if (cur == ST_ON) begin
                t.go = 1'b1;
                t.st = ST_FOUT;
            end
        end
        return t;
    endfunction

endpackage

>>> rtl/core/lfsm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lfsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/lfsm_ramp.sv
// Ramp unit: restoring divider for the Q10 step, then one multiply by the tick count.
// Depends on lfsm_pkg.
module lfsm_ramp #(
    parameter int FULL_DUTY = lfsm_pkg::FULL_DUTY_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lfsm_pkg::ramp_req_t req,
    output lfsm_pkg::ramp_rsp_t rsp
);

    localparam int DW   = $clog2(FULL_DUTY + 1) + lfsm_pkg::FRAC_BITS;
    localparam int PW   = DW + lfsm_pkg::TICK_W;
    localparam int IT_W = $clog2(DW + 1);
    localparam int TW   = lfsm_pkg::TICK_W;
    localparam logic [DW-1:0] DIVIDEND = DW'(FULL_DUTY) << lfsm_pkg::FRAC_BITS;

    typedef enum logic [3:0] {
        R_IDLE = 4'b0001,
        R_DIV  = 4'b0010,
        R_MUL  = 4'b0100,
        R_DONE = 4'b1000
    } ramp_fsm_t;

    ramp_fsm_t         state_reg, state_next;
    logic [DW-1:0]     quo_reg;
    logic [TW-1:0]     rem_reg;
    logic [TW-1:0]     div_reg;
    logic [TW-1:0]     cnt_reg;
    logic [IT_W-1:0]   it_reg;
    logic [PW-1:0]     prod_reg;
    logic [TW:0]       rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign fits   = (rem_sh >= {1'b0, div_reg});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            R_IDLE: if (req.start) state_next = R_DIV;
            R_DIV:  if (it_reg == IT_W'(1)) state_next = R_MUL;
            R_MUL:  state_next = R_DONE;
            R_DONE: state_next = R_IDLE;
            default: state_next = R_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == R_IDLE && req.start) begin
            quo_reg <= DIVIDEND;
            rem_reg <= '0;
            div_reg <= req.ticks;
            cnt_reg <= req.count;
            it_reg  <= IT_W'(DW);
        end else if (state_reg == R_DIV) begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? TW'(rem_sh - {1'b0, div_reg}) : TW'(rem_sh);
            it_reg  <= it_reg - IT_W'(1);
        end
        if (state_reg == R_MUL) begin
            prod_reg <= PW'(quo_reg) * PW'(cnt_reg);
        end
    end

    assign rsp.done  = (state_reg == R_DONE);
    assign rsp.value = prod_reg[lfsm_pkg::FRAC_BITS +: lfsm_pkg::VAL_W];

endmodule

>>> rtl/core/lamp_fade_state_machine.sv
// Top level of the lamp fade controller: per-channel state in a RAM, control FSM,
// result buffer and configuration registers. Depends on lfsm_pkg, lfsm_ram, lfsm_ramp.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+--------------------------------------
//   input    | s_valid / s_ready  | s_channel, s_button_event
//   result   | m_valid / m_ready  | m_out_channel, m_duty, m_last_of_run
//   config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A tick without a fade passes from transfer through C_EVAL to write-back in C_EMIT;
// a fading tick also waits in C_RAMP for the bit-serial divider, which yields
// DW = clog2(FULL_DUTY + 1) + 10 quotient bits, and for the multiply.
// Reset clears the FSM, the result buffer and the per-channel valid bits, so every
// channel reads as off with a zero count. Results wait in a two-entry buffer; a new
// tick can be taken while they drain, and write-back waits until the buffer is empty.
module lamp_fade_state_machine #(
    parameter int CHANNELS  = lfsm_pkg::CHANNELS_DEF,
    parameter int FULL_DUTY = lfsm_pkg::FULL_DUTY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lfsm_pkg::CH_W-1:0]      s_channel,
    input  logic [lfsm_pkg::EV_W-1:0]      s_button_event,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lfsm_pkg::CH_W-1:0]      m_out_channel,
    output logic [lfsm_pkg::DUTY_W-1:0]    m_duty,
    output logic                           m_last_of_run,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfsm_pkg::TICK_W-1:0]    cfg_data
);

    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TW    = lfsm_pkg::TICK_W;
    localparam int VW    = lfsm_pkg::VAL_W;
    localparam int DW    = lfsm_pkg::DUTY_W;
    localparam int MEM_W = lfsm_pkg::ST_W + TW;
    localparam logic [VW-1:0] FULL_V = VW'(FULL_DUTY);
    localparam logic [DW-1:0] FULL_D = DW'(FULL_DUTY);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_EVAL = 4'b0010,
        C_RAMP = 4'b0100,
        C_EMIT = 4'b1000
    } ctl_fsm_t;

    ctl_fsm_t               state_reg, state_next;
    logic [TW-1:0]          fade_in_reg, fade_out_reg;
    logic [AW-1:0]          addr_reg;
    logic [lfsm_pkg::CH_W-1:0] ch_reg;
    logic [lfsm_pkg::EV_W-1:0] ev_reg;
    logic [CHANNELS-1:0]    valid_reg;
    lfsm_pkg::lamp_st_t     st_reg;
    logic [TW-1:0]          cnt_reg;
    logic [1:0]             nres_reg;
    logic [DW-1:0]          d0_reg, d1_reg;
    logic                   fout_reg;
    logic [1:0]             buf_cnt_reg;
    logic [DW-1:0]          buf0_reg, buf1_reg;
    logic [lfsm_pkg::CH_W-1:0] buf_ch_reg;

    logic                   in_xfer, in_range, out_xfer;
    logic                   ram_we;
    logic [MEM_W-1:0]       ram_rdata;
    lfsm_pkg::ramp_req_t    req;
    lfsm_pkg::ramp_rsp_t    rsp;

    lfsm_pkg::lamp_st_t     cur_st, st1;
    logic [TW-1:0]          cur_cnt, cnt1, inc;
    lfsm_pkg::trans_t       tr;
    logic [1:0]             nres;
    logic [DW-1:0]          d0;
    logic                   need_ramp, fout;
    logic [TW-1:0]          ticks;
    logic [DW-1:0]          ramp_duty;

    assign s_ready   = (state_reg == C_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_valid && s_ready;
    assign in_range  = (32'(s_channel) < CHANNELS);
    assign out_xfer  = m_valid && m_ready;
    assign ram_we    = (state_reg == C_EMIT) && (buf_cnt_reg == 2'd0);

    lfsm_ram #(
        .WIDTH(MEM_W),
        .DEPTH(CHANNELS)
    ) u_state_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(addr_reg),
        .wdata({st_reg, cnt_reg}),
        .re   (in_xfer),
        .raddr(AW'(s_channel)),
        .rdata(ram_rdata)
    );

    lfsm_ramp #(
        .FULL_DUTY(FULL_DUTY)
    ) u_ramp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (req),
        .rsp    (rsp)
    );

    always_comb begin
        cur_st    = valid_reg[addr_reg] ? lfsm_pkg::lamp_st_t'(ram_rdata[TW +: lfsm_pkg::ST_W])
                                        : lfsm_pkg::ST_OFF;
        cur_cnt   = valid_reg[addr_reg] ? ram_rdata[TW-1:0] : '0;
        tr        = lfsm_pkg::next_state(cur_st, ev_reg);
        st1       = cur_st;
        cnt1      = cur_cnt;
        nres      = 2'd0;
        d0        = '0;
        need_ramp = 1'b0;
        fout      = 1'b0;
        ticks     = fade_in_reg;
        if (tr.go) begin
            if (cur_st == lfsm_pkg::ST_FIN) begin
                cnt1 = '0;
            end
            if (cur_st == lfsm_pkg::ST_FOUT) begin
                nres = 2'd1;
            end
            st1 = tr.st;
            if (tr.st == lfsm_pkg::ST_OFF) begin
                nres = nres + 2'd1;
            end else if (tr.st == lfsm_pkg::ST_ON) begin
                nres = 2'd1;
                d0   = FULL_D;
            end else begin
                cnt1 = '0;
            end
        end
        inc = (cnt1 == '1) ? cnt1 : cnt1 + TW'(1);
        if (st1 == lfsm_pkg::ST_FIN) begin
            nres = 2'd1;
            if (inc >= fade_in_reg) begin
                st1  = lfsm_pkg::ST_ON;
                cnt1 = '0;
                d0   = FULL_D;
            end else begin
                cnt1      = inc;
                need_ramp = 1'b1;
            end
        end else if (st1 == lfsm_pkg::ST_FOUT) begin
            cnt1 = inc;
            if (inc >= fade_out_reg) begin
                st1  = lfsm_pkg::ST_OFF;
                nres = 2'd2;
            end else begin
                nres      = 2'd1;
                need_ramp = 1'b1;
                fout      = 1'b1;
                ticks     = fade_out_reg;
            end
        end
    end

    assign req.start = (state_reg == C_EVAL) && need_ramp;
    assign req.ticks = ticks;
    assign req.count = cnt1;

    always_comb begin
        if (!fout_reg) begin
            ramp_duty = rsp.value[DW-1:0];
        end else if (rsp.value < FULL_V) begin
            ramp_duty = DW'(FULL_V - rsp.value);
        end else begin
            ramp_duty = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: if (in_xfer && in_range) state_next = C_EVAL;
            C_EVAL: state_next = need_ramp ? C_RAMP : C_EMIT;
            C_RAMP: if (rsp.done) state_next = C_EMIT;
            C_EMIT: if (buf_cnt_reg == 2'd0) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= C_IDLE;
            valid_reg    <= '0;
            buf_cnt_reg  <= 2'd0;
            fade_in_reg  <= lfsm_pkg::FADE_RESET;
            fade_out_reg <= lfsm_pkg::FADE_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    lfsm_pkg::CFG_FADE_IN:  fade_in_reg  <= cfg_data;
                    lfsm_pkg::CFG_FADE_OUT: fade_out_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ram_we) begin
                valid_reg[addr_reg] <= 1'b1;
                buf_cnt_reg         <= nres_reg;
            end else if (out_xfer) begin
                buf_cnt_reg <= buf_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            addr_reg <= AW'(s_channel);
            ch_reg   <= s_channel;
            ev_reg   <= s_button_event;
        end
        if (state_reg == C_EVAL) begin
            st_reg   <= st1;
            cnt_reg  <= cnt1;
            nres_reg <= nres;
            d0_reg   <= d0;
            d1_reg   <= '0;
            fout_reg <= fout;
        end
        if (state_reg == C_RAMP && rsp.done) begin
            d0_reg <= ramp_duty;
        end
        if (ram_we) begin
            buf0_reg   <= d0_reg;
            buf1_reg   <= d1_reg;
            buf_ch_reg <= ch_reg;
        end else if (out_xfer) begin
            buf0_reg <= buf1_reg;
        end
    end

    assign m_valid       = (buf_cnt_reg != 2'd0);
    assign m_out_channel = buf_ch_reg;
    assign m_duty        = buf0_reg;
    assign m_last_of_run = (buf_cnt_reg == 2'd1);

    a_buf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_ramp_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> state_reg == C_RAMP)
        else $error("ramp result outside the ramp wait");

    a_wb_results: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && nres_reg != 2'd0) |=> m_valid)
        else $error("write-back with results left the buffer empty");

    a_duty_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> VW'(m_duty) <= FULL_V)
        else $error("duty above full scale");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for lamp_fade_state_machine: ticks go in on the s_ channel,
// duty updates come back on the m_ channel and are checked against an in-bench lamp model.
// Depends on lfsm_pkg and the lamp_fade_state_machine RTL; nothing else.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfsm_pkg::*;

    localparam int FULL_DUTY = FULL_DUTY_DEF;
    localparam int NUM_CH    = CHANNELS_DEF;
    localparam int SETTLE    = 40;

    localparam logic [EV_W-1:0]      EV_UNDEF    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [DUTY_W-1:0] duty;
        logic              last;
    } duty_upd_t;

    logic                 aclk;
    logic                 aresetn        = 1'b0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [CH_W-1:0]      s_channel      = '0;
    logic [EV_W-1:0]      s_button_event = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [CH_W-1:0]      m_out_channel;
    logic [DUTY_W-1:0]    m_duty;
    logic                 m_last_of_run;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [TICK_W-1:0]    cfg_data       = '0;

    lamp_st_t          lamp_st [NUM_CH];
    logic [TICK_W-1:0] fade_cnt [NUM_CH];
    logic [TICK_W-1:0] fade_in_len;
    logic [TICK_W-1:0] fade_out_len;
    logic [DUTY_W-1:0] tick_duty [2];
    int                tick_n;
    duty_upd_t         duty_q [$];

    bit no_idle  = 1'b0;
    int hold_req = 0;
    int tick_cnt = 0;
    int upd_cnt  = 0;
    int wr_cnt   = 0;
    int err_cnt  = 0;

    lamp_fade_state_machine u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_channel      (s_channel),
        .s_button_event (s_button_event),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_channel  (m_out_channel),
        .m_duty         (m_duty),
        .m_last_of_run  (m_last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic [TICK_W-1:0] ramp_term(logic [TICK_W-1:0] cnt,
                                                   logic [TICK_W-1:0] len);
        longint unsigned step;
        longint unsigned prod;
        if (len == 0) begin
            return '0;
        end
        step = (longint'(FULL_DUTY) << FRAC_BITS) / len;
        prod = (step * cnt) >> FRAC_BITS;
        return prod[TICK_W-1:0];
    endfunction

    function automatic void emit_duty(logic [TICK_W-1:0] d);
        if (tick_n < 2) begin
            tick_duty[tick_n] = d[DUTY_W-1:0];
            tick_n++;
        end
    endfunction

    function automatic void change_state(int ch, lamp_st_t nxt);
        if (lamp_st[ch] == ST_FIN) begin
            fade_cnt[ch] = '0;
        end else if (lamp_st[ch] == ST_FOUT) begin
            emit_duty('0);
        end
        lamp_st[ch] = nxt;
        case (nxt)
            ST_OFF: emit_duty('0);
            ST_ON: emit_duty(TICK_W'(FULL_DUTY));
            default: fade_cnt[ch] = '0;
        endcase
    endfunction

    task automatic predict_tick(input int ch, input logic [EV_W-1:0] ev);
        logic [TICK_W:0]   cnt;
        logic [TICK_W-1:0] len;
        logic [TICK_W-1:0] r;
        bit                fading_in;
        tick_n = 0;
        if (ch >= NUM_CH) begin
            return;
        end
        case (lamp_st[ch])
            ST_OFF: begin
                if (ev == EV_SHORT) change_state(ch, ST_FIN);
                else if (ev == EV_LONG) change_state(ch, ST_ON);
            end
            ST_ON: begin
                if (ev == EV_SHORT) change_state(ch, ST_FOUT);
                else if (ev == EV_LONG) change_state(ch, ST_OFF);
            end
            default: begin
                if (ev == EV_LONG) change_state(ch, ST_OFF);
            end
        endcase
        if (lamp_st[ch] == ST_FIN || lamp_st[ch] == ST_FOUT) begin
            fading_in = (lamp_st[ch] == ST_FIN);
            len = fading_in ? fade_in_len : fade_out_len;
            cnt = {1'b0, fade_cnt[ch]} + 1'b1;
            if (cnt > 65535) cnt = {1'b0, {TICK_W{1'b1}}};
            fade_cnt[ch] = cnt[TICK_W-1:0];
            if (cnt >= len) begin
                change_state(ch, fading_in ? ST_ON : ST_OFF);
            end else begin
                r = ramp_term(cnt[TICK_W-1:0], len);
                if (fading_in) emit_duty(r);
                else emit_duty(r < FULL_DUTY ? TICK_W'(FULL_DUTY) - r : '0);
            end
        end
        for (int i = 0; i < tick_n; i++) begin
            duty_q.push_back('{ch: ch[CH_W-1:0], duty: tick_duty[i], last: (i == tick_n - 1)});
        end
    endtask

    task automatic send_tick(input logic [CH_W-1:0] ch, input logic [EV_W-1:0] ev);
        while (!no_idle && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_channel      <= ch;
        s_button_event <= ev;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        predict_tick(int'(ch), ev);
        tick_cnt++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FADE_IN) fade_in_len = val;
        else if (idx == CFG_FADE_OUT) fade_out_len = val;
        wr_cnt++;
        @(posedge aclk);
    endtask

    // Waits until every expected update has arrived, then lets the block settle
    // so that a tick that produced no update has also finished.
    task automatic drain();
        s_valid <= 1'b0;
        while (duty_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [EV_W-1:0] pick_event();
        int r;
        r = $urandom_range(99);
        if (r < 62) return EV_NONE;
        if (r < 82) return EV_SHORT;
        if (r < 92) return EV_LONG;
        return EV_UNDEF;
    endfunction

    task automatic set_fades(input logic [TICK_W-1:0] in_len, input logic [TICK_W-1:0] out_len);
        drain();
        write_reg(CFG_FADE_IN, in_len);
        write_reg(CFG_FADE_OUT, out_len);
    endtask

    task automatic random_ticks(input int count);
        for (int i = 0; i < count; i++) begin
            send_tick(CH_W'($urandom_range(NUM_CH - 1)), pick_event());
        end
    endtask

    task automatic test_reset_defaults();
        send_tick(2'd0, EV_SHORT);
        send_tick(2'd0, EV_NONE);
        send_tick(2'd0, EV_UNDEF);
        send_tick(2'd0, EV_LONG);
    endtask

    task automatic test_transitions();
        set_fades(16'd3, 16'd2);
        send_tick(2'd1, EV_NONE);
        send_tick(2'd1, EV_LONG);
        send_tick(2'd1, EV_NONE);
        send_tick(2'd1, EV_SHORT);
        send_tick(2'd1, EV_SHORT);
        send_tick(2'd1, EV_SHORT);
        send_tick(2'd1, EV_SHORT);
        send_tick(2'd1, EV_UNDEF);
        send_tick(2'd1, EV_LONG);
        send_tick(2'd2, EV_LONG);
        send_tick(2'd2, EV_SHORT);
        send_tick(2'd2, EV_LONG);
    endtask

    task automatic test_extreme_lengths();
        set_fades(16'd0, 16'd0);
        send_tick(2'd3, EV_SHORT);
        send_tick(2'd3, EV_SHORT);
        set_fades(16'hFFFF, 16'hFFFF);
        write_reg(CFG_SPARE_A, TICK_W'($urandom));
        write_reg(CFG_SPARE_B, TICK_W'($urandom));
        send_tick(2'd0, EV_SHORT);
        send_tick(2'd0, EV_NONE);
        send_tick(2'd0, EV_LONG);
        send_tick(2'd0, EV_LONG);
        send_tick(2'd0, EV_SHORT);
        // The fade-out length shrinks under a running fade, which must end on the next tick.
        set_fades(16'hFFFF, 16'd1);
        send_tick(2'd0, EV_NONE);
    endtask

    task automatic test_random_phases();
        set_fades(16'd4, 16'd6);
        random_ticks(160);
        set_fades(16'd1, 16'd1);
        random_ticks(160);
        set_fades(16'd0, 16'd9);
        random_ticks(160);
        set_fades(16'd17, 16'd2);
        random_ticks(160);
        set_fades(16'hFFFF, 16'd0);
        random_ticks(160);
        set_fades(16'd3, 16'hFFFF);
        random_ticks(160);
        set_fades(TICK_W'($urandom_range(2, 40)), TICK_W'($urandom_range(0, 40)));
        random_ticks(160);
    endtask

    task automatic test_back_to_back();
        set_fades(16'd5, 16'd5);
        no_idle = 1'b1;
        random_ticks(100);
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        set_fades(16'd50, 16'd50);
        hold_req = 400;
        random_ticks(30);
    endtask

    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req > 0) begin
                m_ready <= 1'b0;
                hold_left = hold_req - 1;
                hold_req = 0;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= 9);
            end
        end
    end

    always @(negedge aclk) begin : check_updates
        duty_upd_t want;
        if (aresetn && m_valid && m_ready) begin
            upd_cnt++;
            if (duty_q.size() == 0) begin
                $error("unexpected duty update: channel %0d duty %0d", m_out_channel, m_duty);
                err_cnt++;
            end else begin
                want = duty_q.pop_front();
                if (m_out_channel !== want.ch) begin
                    $error("m_out_channel: expected %0d, got %0d", want.ch, m_out_channel);
                    err_cnt++;
                end
                if (m_duty !== want.duty) begin
                    $error("m_duty: expected %0d, got %0d", want.duty, m_duty);
                    err_cnt++;
                end
                if (m_last_of_run !== want.last) begin
                    $error("m_last_of_run: expected %0d, got %0d", want.last, m_last_of_run);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_CH; i++) begin
            lamp_st[i]  = ST_OFF;
            fade_cnt[i] = '0;
        end
        fade_in_len  = FADE_RESET;
        fade_out_len = FADE_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_transitions();
        test_extreme_lengths();
        test_random_phases();
        test_back_to_back();
        test_backpressure();
        drain();

        $display("tb_top: %0d lamp ticks sent, %0d duty updates checked, %0d register writes",
                 tick_cnt, upd_cnt, wr_cnt);
        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
